// ===== sv/kvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kvt_pkg;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_ERASE  = 3'd1;
	localparam logic [2:0] OP_CLEAR  = 3'd2;
	localparam logic [2:0] OP_LOOKUP = 3'd3;
	localparam logic [2:0] OP_COUNT  = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic mv_read;
		logic mv_write;
		logic res_load;
	} kvt_cmd_t;

	typedef struct packed {
		logic scan_op;
		logic erase_op;
		logic key_hit;
		logic scan_done;
	} kvt_sts_t;

endpackage
`default_nettype wire

// ===== sv/keyed_value_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// unordered table of up to TABLE_DEPTH key/value pairs held in two single-port-read
// RAMs; one item at a time. insert, clear and unused ops go from the exec state
// straight to the done state; lookup and count scan every held entry, one per cycle
// through the RAM read port; erase scans up to the first matching key and then
// reads the last entry and writes it into the freed slot. a new item is taken as
// soon as the previous one is finished, while its result may still wait in the
// output register.
module keyed_value_table
	import kvt_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic        [2:0]  op,
	input  wire logic signed [31:0] key_in,
	input  wire logic        [31:0] value_in,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [1:0]  status,
	output logic                    found,
	output logic             [31:0] value_out,
	output logic             [5:0]  match_count,
	output logic             [5:0]  fill_level
);

	kvt_cmd_t cmd;
	kvt_sts_t sts;

	kvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kvt_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.key_in     (key_in),
		.value_in   (value_in),
		.status     (status),
		.found      (found),
		.value_out  (value_out),
		.match_count(match_count),
		.fill_level (fill_level)
	);

endmodule
`default_nettype wire

// ===== sv/kvt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/kvt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kvt_ctrl
	import kvt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire kvt_sts_t sts,
	output kvt_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:    cmd.load = in_valid;
			S_EXEC:    cmd.exec = 1'b1;
			S_SCAN:    cmd.scan = 1'b1;
			S_MOVE_RD: cmd.mv_read = 1'b1;
			S_MOVE_WR: cmd.mv_write = 1'b1;
			S_DONE:    cmd.res_load = slot_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ((state_q == S_DONE) && slot_free) || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= sts.scan_op ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					if (sts.erase_op && sts.key_hit) begin
						state_q <= S_MOVE_RD;
					end else if (sts.scan_done) begin
						state_q <= S_DONE;
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/kvt_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kvt_dpath
	import kvt_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kvt_cmd_t           cmd,
	output kvt_sts_t                sts,
	input  wire logic        [2:0]  op,
	input  wire logic signed [31:0] key_in,
	input  wire logic        [31:0] value_in,
	output logic             [1:0]  status,
	output logic                    found,
	output logic             [31:0] value_out,
	output logic             [5:0]  match_count,
	output logic             [5:0]  fill_level
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [2:0]             op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          iss_q;
	logic                   rd_vld_s1;
	logic [AW-1:0]          rd_idx_s1;
	logic [AW-1:0]          hit_idx_q;
	logic                   res_found_q;
	logic                   res_full_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic [CW-1:0]          res_cnt_q;

	logic [1:0]  status_q;
	logic        found_q;
	logic [31:0] value_out_q;
	logic [5:0]  match_count_q;
	logic [5:0]  fill_level_q;

	logic                   full;
	logic                   more;
	logic [CW-1:0]          last_idx;
	logic                   ins_we;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr;
	logic [KEY_WIDTH-1:0]   key_wdata;
	logic [VALUE_WIDTH-1:0] val_wdata;
	logic [KEY_WIDTH-1:0]   key_rdata;
	logic [VALUE_WIDTH-1:0] val_rdata;
	logic                   key_eq;
	logic                   val_eq;
	logic [1:0]             status_d;

	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign more     = (iss_q < count_q);
	assign last_idx = count_q - CW'(1);
	assign ins_we   = cmd.exec && (op_q == OP_INSERT) && !full;
	assign we       = ins_we || cmd.mv_write;
	assign waddr    = cmd.mv_write ? hit_idx_q : count_q[AW-1:0];
	assign raddr    = cmd.mv_read ? last_idx[AW-1:0] : iss_q[AW-1:0];
	assign key_wdata = cmd.mv_write ? key_rdata : key_q;
	assign val_wdata = cmd.mv_write ? val_rdata : val_q;
	assign key_eq   = (key_rdata == key_q);
	assign val_eq   = (val_rdata == val_q);

	kvt_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(key_wdata),
		.raddr(raddr),
		.rdata(key_rdata)
	);

	kvt_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_val_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(val_wdata),
		.raddr(raddr),
		.rdata(val_rdata)
	);

	assign sts.scan_op   = (op_q == OP_ERASE) || (op_q == OP_LOOKUP) || (op_q == OP_COUNT);
	assign sts.erase_op  = (op_q == OP_ERASE);
	assign sts.key_hit   = rd_vld_s1 && key_eq;
	assign sts.scan_done = !rd_vld_s1 && !more;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			key_q <= KEY_WIDTH'($unsigned(key_in));
			val_q <= VALUE_WIDTH'(value_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			iss_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			hit_idx_q   <= '0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
			res_val_q   <= '0;
			res_cnt_q   <= '0;
		end else if (cmd.load) begin
			iss_q       <= '0;
			rd_vld_s1   <= 1'b0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
			res_val_q   <= '0;
			res_cnt_q   <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan && more;
			if (cmd.exec) begin
				if (op_q == OP_INSERT) begin
					res_full_q <= full;
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end else if (op_q == OP_CLEAR) begin
					count_q <= '0;
				end
			end
			if (cmd.scan) begin
				if (more) begin
					rd_idx_s1 <= iss_q[AW-1:0];
					iss_q     <= iss_q + CW'(1);
				end
				if (rd_vld_s1) begin
					case (op_q)
						OP_ERASE: begin
							if (key_eq && !res_found_q) begin
								res_found_q <= 1'b1;
								hit_idx_q   <= rd_idx_s1;
							end
						end
						OP_LOOKUP: begin
							if (key_eq) begin
								res_found_q <= 1'b1;
								res_val_q   <= val_rdata;
							end
						end
						OP_COUNT: begin
							if (val_eq) begin
								res_cnt_q <= res_cnt_q + CW'(1);
							end
						end
						default: ;
					endcase
				end
			end
			if (cmd.mv_write) begin
				count_q <= last_idx;
			end
		end
	end

	always_comb begin
		case (op_q)
			OP_INSERT: status_d = res_full_q ? STAT_FULL : STAT_OK;
			OP_ERASE,
			OP_LOOKUP: status_d = res_found_q ? STAT_OK : STAT_MISS;
			default:   status_d = STAT_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q      <= status_d;
			found_q       <= res_found_q;
			value_out_q   <= 32'(res_val_q);
			match_count_q <= 6'(res_cnt_q);
			fill_level_q  <= 6'(count_q);
		end
	end

	assign status      = status_q;
	assign found       = found_q;
	assign value_out   = value_out_q;
	assign match_count = match_count_q;
	assign fill_level  = fill_level_q;

endmodule
`default_nettype wire

// ===== sv/kvt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kvt_checker
	import kvt_pkg::*;
#(
	parameter int TABLE_DEPTH = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic        found,
	input wire logic [31:0] value_out,
	input wire logic [5:0]  fill_level
);

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fill_level))
		else $error("result item changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK) || (status == STAT_FULL) || (status == STAT_MISS))
		else $error("status code out of range");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == STAT_OK)
		else $error("found with non-ok status");

	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> fill_level == 6'(TABLE_DEPTH))
		else $error("full reported below capacity");

	a_value_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> value_out == 32'd0)
		else $error("value given without a match");

endmodule

bind keyed_value_table kvt_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_kvt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.found     (found),
	.value_out (value_out),
	.fill_level(fill_level)
);
`default_nettype wire
